@@ design/simon128_256_block_cipher_core_defines.svh @@
// Assertion macros shared by the SIMON 128/256 core
`ifndef SIMON128_256_BLOCK_CIPHER_CORE_DEFINES_SVH
`define SIMON128_256_BLOCK_CIPHER_CORE_DEFINES_SVH

// cond must hold in the same cycle as trig
`define SIMON_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// cond must hold in the cycle after trig
`define SIMON_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/simon_pkg.sv @@
// Shared types and constants for the SIMON 128/256 core
`default_nettype none
package simon_pkg;

  localparam int WORD_BITS  = 64;
  localparam int ROUNDS     = 72;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_IDX_W  = $clog2(KEY_WORDS);
  localparam int Z_LEN      = 62;
  localparam int Z_IDX_W    = $clog2(Z_LEN);
  localparam int ROUND_CONST = 3;

  // z4 sequence, element 0 is the leftmost bit
  localparam logic [0:Z_LEN-1] Z_SEQ =
    62'b11010001_11100110_10110110_00100000_01011100_00110010_10010011_101111;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  action;
    word_t block_high;
    word_t block_low;
  } block_in_t;

  typedef struct packed {
    word_t result_high;
    word_t result_low;
  } block_out_t;

  // key chain motion: advance takes the upper neighbor, retreat the lower one
  typedef struct packed {
    logic advance;
    logic retreat;
  } chain_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic decrypt;
  } round_ctrl_t;

endpackage
`default_nettype wire

@@ design/simon_key_cell.sv @@
// One round key cell of the rotating key chain
`default_nettype none
module simon_key_cell (
  input  wire                   clk,
  input  simon_pkg::chain_ctrl_t ctrl,
  input  simon_pkg::word_t      from_next,
  input  simon_pkg::word_t      from_prev,
  output simon_pkg::word_t      key
);

  simon_pkg::word_t key_reg;

  // advance and retreat never rise together; neither set holds the key
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      key_reg <= from_next;
    end else if (ctrl.retreat) begin
      key_reg <= from_prev;
    end
  end

  assign key = key_reg;

endmodule
`default_nettype wire

@@ design/simon_round.sv @@
// Feistel round unit: one SIMON round per cycle while step is set, on the x/y halves
`default_nettype none
module simon_round (
  input  wire                    clk,
  input  simon_pkg::round_ctrl_t ctrl,
  input  simon_pkg::block_in_t   block,
  input  simon_pkg::word_t       round_key,
  output simon_pkg::block_out_t  result
);

  localparam int W = simon_pkg::WORD_BITS;

  simon_pkg::word_t x;
  simon_pkg::word_t y;
  simon_pkg::word_t x_next;
  simon_pkg::word_t y_next;

  function automatic simon_pkg::word_t round_f(input simon_pkg::word_t v);
    simon_pkg::word_t r1;
    simon_pkg::word_t r2;
    simon_pkg::word_t r8;
    r1 = {v[W-2:0], v[W-1]};
    r2 = {v[W-3:0], v[W-1:W-2]};
    r8 = {v[W-9:0], v[W-1:W-8]};
    return (r1 & r8) ^ r2;
  endfunction

  always_comb begin
    x_next = x;
    y_next = y;
    if (ctrl.load) begin
      x_next = block.block_high;
      y_next = block.block_low;
    end else if (ctrl.step) begin
      if (ctrl.decrypt) begin
        // inverse round: y absorbs the key, x takes old y
        y_next = x ^ round_f(y) ^ round_key;
        x_next = y;
      end else begin
        x_next = y ^ round_f(x) ^ round_key;
        y_next = x;
      end
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
  end

  assign result.result_high = x;
  assign result.result_low  = y;

endmodule
`default_nettype wire

@@ design/simon128_256_block_cipher_core.sv @@
// Top level of the SIMON 128/256 block cipher core
`default_nettype none
`include "simon128_256_block_cipher_core_defines.svh"
// SIMON 128/256 core. Load the 256-bit key through the cfg channel (cfg_index
// 0 is the least significant word). Issue a block by raising start while busy
// is low; block.action picks encrypt (0) or decrypt (1). The result shows on
// result, flagged by done for exactly one cycle, and must be captured then:
// there is no way to stall it. A block runs 72 rounds after the accepting
// edge, one per cycle through the single round unit, then the done cycle,
// during which busy is already low so the next block can be issued. Round
// keys live in a ring of 72 key cells that rotates one place per round
// (forward to encrypt, backward to decrypt) and ends each block back in
// home position. After reset and after every key word write the schedule is
// rebuilt by shifting 72 words into the ring, with busy high and cfg_ready
// low throughout. cfg_ready is also low while start is high.
module simon128_256_block_cipher_core #(
  parameter int ROUNDS = simon_pkg::ROUNDS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  simon_pkg::block_in_t         block,
  output logic                         done,
  output simon_pkg::block_out_t        result,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [simon_pkg::KEY_IDX_W-1:0] cfg_index,
  input  simon_pkg::word_t             cfg_data
);

  localparam int STEP_W = $clog2(ROUNDS);
  localparam int W      = simon_pkg::WORD_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPAND = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [STEP_W-1:0]              step;
  logic [STEP_W-1:0]              step_next;
  logic [simon_pkg::Z_IDX_W-1:0]  zidx;
  logic [simon_pkg::Z_IDX_W-1:0]  zidx_next;
  logic                           dir;
  logic                           done_next;
  simon_pkg::word_t               key_word [simon_pkg::KEY_WORDS];

  simon_pkg::word_t               keys [ROUNDS];
  simon_pkg::word_t               tail_in;
  simon_pkg::word_t               sched_word;
  simon_pkg::word_t               t1;
  simon_pkg::word_t               t2;
  simon_pkg::word_t               round_key;
  simon_pkg::chain_ctrl_t         chain_ctrl;
  simon_pkg::round_ctrl_t         round_ctrl;

  logic start_ok;
  logic cfg_ok;
  logic last_step;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;
  assign start_ok  = start && !busy;
  assign cfg_ok    = cfg_valid && cfg_ready;
  assign last_step = (step == STEP_W'(ROUNDS - 1));

  // ---------------------------------------------------------------
  // Key schedule word entering the ring tail during expansion.
  // Ring tail holds k[i-1], tail-2 k[i-3], tail-3 k[i-4].
  // The first KEY_WORDS shifts feed the raw key words.
  // ---------------------------------------------------------------
  always_comb begin
    t1 = {keys[ROUNDS-1][2:0], keys[ROUNDS-1][W-1:3]} ^ keys[ROUNDS-3];
    t2 = t1 ^ {t1[0], t1[W-1:1]};
    if (step < STEP_W'(simon_pkg::KEY_WORDS)) begin
      sched_word = key_word[step[simon_pkg::KEY_IDX_W-1:0]];
    end else begin
      sched_word = ~keys[ROUNDS-4] ^ t2 ^ W'(simon_pkg::ROUND_CONST)
                   ^ W'(simon_pkg::Z_SEQ[zidx]);
    end
  end

  assign tail_in = (state == ST_EXPAND) ? sched_word : keys[0];

  assign chain_ctrl.advance = (state == ST_EXPAND) || ((state == ST_RUN) && !dir);
  assign chain_ctrl.retreat = (state == ST_RUN) && dir;

  // ring of key cells; encrypt reads the head, decrypt the tail
  for (genvar j = 0; j < ROUNDS; j++) begin : g_ring
    simon_pkg::word_t nxt;
    simon_pkg::word_t prv;
    if (j == ROUNDS - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = keys[j+1];
    end
    if (j == 0) begin : g_head
      assign prv = keys[ROUNDS-1];
    end else begin : g_body
      assign prv = keys[j-1];
    end
    simon_key_cell u_cell (
      .clk       (clk),
      .ctrl      (chain_ctrl),
      .from_next (nxt),
      .from_prev (prv),
      .key       (keys[j])
    );
  end

  assign round_key = dir ? keys[ROUNDS-1] : keys[0];

  assign round_ctrl.load    = start_ok;
  assign round_ctrl.step    = (state == ST_RUN);
  assign round_ctrl.decrypt = dir;

  simon_round u_round (
    .clk       (clk),
    .ctrl      (round_ctrl),
    .block     (block),
    .round_key (round_key),
    .result    (result)
  );

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    step_next  = step;
    zidx_next  = zidx;
    done_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start_ok) begin
          state_next = ST_RUN;
          step_next  = '0;
        end else if (cfg_ok) begin
          state_next = ST_EXPAND;
          step_next  = '0;
          zidx_next  = '0;
        end
      end
      ST_EXPAND: begin
        step_next = step + STEP_W'(1);
        if (step >= STEP_W'(simon_pkg::KEY_WORDS)) begin
          zidx_next = (zidx == simon_pkg::Z_IDX_W'(simon_pkg::Z_LEN - 1)) ?
                      '0 : zidx + simon_pkg::Z_IDX_W'(1);
        end
        if (last_step) begin
          state_next = ST_IDLE;
        end
      end
      ST_RUN: begin
        step_next = step + STEP_W'(1);
        if (last_step) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EXPAND;
      step  <= '0;
      zidx  <= '0;
      done  <= 1'b0;
      for (int i = 0; i < simon_pkg::KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
    end else begin
      state <= state_next;
      step  <= step_next;
      zidx  <= zidx_next;
      done  <= done_next;
      if (cfg_ok) begin
        key_word[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_ok) begin
      dir <= block.action;
    end
  end

  `SIMON_ASSERT_SAME(a_done_idle, clk, rst, done, state == ST_IDLE,
    "done raised while the core is not idle")
  `SIMON_ASSERT_SAME(a_done_after_run, clk, rst, done, $past(state) == ST_RUN,
    "done not preceded by the last round")
  `SIMON_ASSERT_NEXT(a_start_runs, clk, rst, start_ok, state == ST_RUN && step == '0,
    "accepted block did not start at round zero")
  `SIMON_ASSERT_NEXT(a_cfg_expands, clk, rst, cfg_ok, state == ST_EXPAND && step == '0,
    "key write did not restart the key schedule")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the SIMON 128/256 block cipher core
module tb_top;
  import simon_pkg::*;

  // word actions and the handful of fixed numbers the run depends on
  localparam bit          ACT_ENCRYPT  = 1'b0;
  localparam bit          ACT_DECRYPT  = 1'b1;
  localparam int          CLK_HALF     = 6;
  localparam int          RST_CYCLES   = 12;
  localparam int          SETTLE       = 80;        // longer than one block takes
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          PHASES       = 10;
  localparam int          PHASE_WORDS  = 188;       // random words per key phase
  localparam int          IDLE_PCT     = 17;
  localparam int          MAX_SHOWN    = 200;       // cap on mismatch lines
  localparam int          TRIP_DEPTH   = 16;        // recent results kept for round trips

  // --------------------------------------------------------------------------
  // Scoreboard: carries its own copy of the key and the expanded schedule,
  // works out each cipher result when a word is issued and compares the
  // results as they show up on the result port, oldest first.
  // --------------------------------------------------------------------------
  class simon_block_checker;
    // z4 sequence, element 0 leftmost; schedule constant c = 3
    localparam logic [0:61] Z4 =
      62'b11010001_11100110_10110110_00100000_01011100_00110010_10010011_101111;
    localparam word_t SCHED_C = 64'd3;

    word_t        key_words[KEY_WORDS];
    word_t        sched[ROUNDS];
    block_out_t   pending[$];
    int unsigned  issued, encrypts, decrypts, checked, errors, shown, key_writes;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      build_schedule();
    endfunction

    static function word_t rot_left(word_t v, int n);
      return (v << n) | (v >> (WORD_BITS - n));
    endfunction

    static function word_t rot_right(word_t v, int n);
      return (v >> n) | (v << (WORD_BITS - n));
    endfunction

    static function word_t mix(word_t v);
      return (rot_left(v, 1) & rot_left(v, 8)) ^ rot_left(v, 2);
    endfunction

    function void build_schedule();
      word_t t;
      for (int i = 0; i < KEY_WORDS; i++) sched[i] = key_words[i];
      for (int i = KEY_WORDS; i < ROUNDS; i++) begin
        t = rot_right(sched[i-1], 3) ^ sched[i-3];
        t = t ^ rot_right(t, 1);
        sched[i] = ~sched[i-KEY_WORDS] ^ t ^ word_t'(Z4[(i-KEY_WORDS) % 62]) ^ SCHED_C;
      end
    endfunction

    function void load_key(int idx, word_t data);
      key_words[idx] = data;
      key_writes++;
      build_schedule();
    endfunction

    function block_out_t cipher(block_in_t b);
      word_t x, y, t;
      block_out_t r;
      x = b.block_high;
      y = b.block_low;
      if (b.action == ACT_ENCRYPT) begin
        for (int i = 0; i < ROUNDS; i++) begin
          t = x;
          x = y ^ mix(x) ^ sched[i];
          y = t;
        end
      end else begin
        for (int i = ROUNDS - 1; i >= 0; i--) begin
          t = y;
          y = x ^ mix(y) ^ sched[i];
          x = t;
        end
      end
      r.result_high = x;
      r.result_low  = y;
      return r;
    endfunction

    function void note_issue(block_in_t b);
      pending.push_back(cipher(b));
      issued++;
      if (b.action == ACT_ENCRYPT) encrypts++;
      else decrypts++;
    endfunction

    function void check_output(block_out_t got);
      block_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown++ < MAX_SHOWN)
          $display("%0t: unexpected result %h_%h with no word outstanding",
                   $time, got.result_high, got.result_low);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.result_high !== want.result_high) begin
        errors++;
        if (shown++ < MAX_SHOWN)
          $display("%0t: result %0d result_high expected %h actual %h",
                   $time, checked, want.result_high, got.result_high);
      end
      if (got.result_low !== want.result_low) begin
        errors++;
        if (shown++ < MAX_SHOWN)
          $display("%0t: result %0d result_low expected %h actual %h",
                   $time, checked, want.result_low, got.result_low);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  block_in_t              blk_word;
  logic                   done;
  block_out_t             result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [KEY_IDX_W-1:0]   cfg_index;
  word_t                  cfg_data;

  simon128_256_block_cipher_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .block     (blk_word),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  simon_block_checker book;
  int unsigned        cycles;         // starts at zero, counted by the watchdog only
  bit                 quiet;          // set for the stretch with no sender gaps
  int unsigned        key_sets;
  block_in_t          recent[$];      // inverse words of recent results, for round trips

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Results cannot be held off: every done cycle is one result, taken at the edge.
  always @(posedge clk) begin
    if (!rst && done) book.check_output(result);
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycles, book.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly random, with a good share of all-zero, all-one, single-bit and single-clear-bit words
  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = '1;
      2:       w = word_t'(1) << $urandom_range(WORD_BITS - 1);
      3:       w = ~(word_t'(1) << $urandom_range(WORD_BITS - 1));
      default: w = {$urandom(), $urandom()};
    endcase
    return w;
  endfunction

  // Issue one word. start stays high afterwards so back-to-back words need no
  // extra edge; a gap lowers it at its own falling edge and scrambles the bus.
  task automatic send_block(input block_in_t b);
    int gap;
    block_in_t inv;
    block_out_t out;
    gap = 0;
    if (!quiet && $urandom_range(99) < IDLE_PCT)
      gap = ($urandom_range(7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      start    <= 1'b0;
      blk_word <= {1'($urandom()), $urandom(), $urandom(), $urandom(), $urandom()};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    blk_word <= b;
    do @(posedge clk); while (busy);
    // accepted at this edge
    out = book.cipher(b);
    book.note_issue(b);
    inv.action     = ~b.action;
    inv.block_high = out.result_high;
    inv.block_low  = out.result_low;
    recent.push_back(inv);
    if (recent.size() > TRIP_DEPTH) void'(recent.pop_front());
  endtask

  task automatic send_fields(input bit act, input word_t hi, input word_t lo);
    block_in_t b;
    b.action     = act;
    b.block_high = hi;
    b.block_low  = lo;
    send_block(b);
  endtask

  // Stop issuing and wait until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  // Key word write; only called after drain(), then waits for cfg_ready while the schedule rebuilds
  task automatic write_key(input int idx, input word_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[KEY_IDX_W-1:0];
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.load_key(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= {$urandom(), $urandom()};
  endtask

  task automatic write_all_keys(input word_t k0, input word_t k1,
                                input word_t k2, input word_t k3);
    drain();
    write_key(0, k0);
    write_key(1, k1);
    write_key(2, k2);
    write_key(3, k3);
    key_sets++;
  endtask

  // New key setting for a random phase; some phases change only a few words
  task automatic new_key_phase(input int phase);
    int mask;
    drain();
    case (phase)
      0: for (int i = 0; i < KEY_WORDS; i++) write_key(i, '1);
      1: for (int i = 0; i < KEY_WORDS; i++) write_key(i, '0);
      2: for (int i = 0; i < KEY_WORDS; i++)
           write_key(i, (i % 2) ? 64'haaaa_aaaa_aaaa_aaaa : 64'h5555_5555_5555_5555);
      default: begin
        mask = (phase % 3 == 0) ? $urandom_range(1, 14) : 15;
        for (int i = 0; i < KEY_WORDS; i++)
          if (mask[i]) write_key(i, pick_word());
      end
    endcase
    key_sets++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    block_in_t b;
    int        r;
    book      = new();
    rst       = 1'b1;
    start     = 1'b0;
    blk_word  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    key_sets  = 1;        // the all-zero key after reset
    repeat (RST_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed: schedule of the all-zero key straight out of reset
    send_fields(ACT_ENCRYPT, '0, '0);
    send_fields(ACT_ENCRYPT, '1, '1);
    send_fields(ACT_DECRYPT, '0, '0);
    send_fields(ACT_DECRYPT, '1, '1);
    send_fields(ACT_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_fields(ACT_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_fields(ACT_ENCRYPT, '0, '1);

    // Published 128/256 vector, then both directions of it
    write_all_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                   64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    send_fields(ACT_ENCRYPT, 64'h74206e69206d6f6f, 64'h6d69732061207369);
    send_fields(ACT_DECRYPT, 64'h8d2b5579afc8a3a0, 64'h3bf72a87efe7b868);
    send_block(recent[$]);                 // encrypt must undo the decrypt
    send_fields(ACT_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    send_block(recent[$]);
    send_fields(ACT_DECRYPT, '1, '0);
    send_block(recent[$]);                 // and encrypt undoes a decrypt

    // Key words at the extremes
    write_all_keys('1, '1, '1, '1);
    send_fields(ACT_ENCRYPT, '0, '0);
    send_fields(ACT_DECRYPT, '0, '0);
    send_fields(ACT_ENCRYPT, '1, '1);
    write_all_keys(64'h1, 64'h0, 64'h0, 64'h8000_0000_0000_0000);
    send_fields(ACT_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block(recent[$]);

    // Random phases, each under a fresh key setting. About a quarter of the
    // words feed a recent result back the other way, so round trips get
    // checked end to end; phase 4 runs with no sender gaps at all.
    for (int p = 0; p < PHASES; p++) begin
      new_key_phase(p);
      quiet = (p == 4);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 6 && n == PHASE_WORDS / 2) drain();   // let the pipe run dry once
        r = $urandom_range(99);
        if (r < 25 && recent.size() > 0) begin
          b = recent[$urandom_range(recent.size() - 1)];
        end else begin
          b.action     = 1'($urandom_range(1));
          b.block_high = pick_word();
          b.block_low  = pick_word();
        end
        send_block(b);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d words (%0d encrypt, %0d decrypt) under %0d key settings,",
             book.issued, book.encrypts, book.decrypts, key_sets);
    $display("with %0d key word writes and %0d results compared, %0d errors.",
             book.key_writes, book.checked, book.errors);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ simon128_256_block_cipher_core.f @@
+incdir+design
design/simon_pkg.sv
design/simon_key_cell.sv
design/simon_round.sv
design/simon128_256_block_cipher_core.sv
tb/tb_top.sv
